/* sv/tpm_pkg.sv */
// Shared types, constants and matching function of the tunnel point match table.
`timescale 1ns / 1ps

package tpm_pkg;

    localparam int TPM_TABLE_DEPTH    = 16;
    localparam int CMD_QUEUE_DEPTH    = 2;
    localparam int ADDR_W             = 16;
    localparam int ID_W               = 16;
    localparam int CLASS_W            = 8;
    localparam int KIND_W             = 2;
    localparam int POINT_W            = 3;
    localparam int SLOT_W             = 4;

    localparam logic [CLASS_W-1:0] IGNORE_CLASS_RESET = 8'd2;

    localparam logic [KIND_W-1:0] KIND_ACTIVATE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEACTIVATE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLASSIFY   = 2'd2;

    localparam logic [POINT_W-1:0] POINT_NONE = 3'd0;
    localparam logic [POINT_W-1:0] POINT_IN   = 3'd1;
    localparam logic [POINT_W-1:0] POINT_OUT  = 3'd2;
    localparam logic [POINT_W-1:0] POINT_FROM = 3'd3;
    localparam logic [POINT_W-1:0] POINT_TO   = 3'd4;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACTIVATE,
        OP_DEACTIVATE,
        OP_CLASSIFY,
        OP_BYPASS
    } op_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ADDR_W-1:0]  addr_in;
        logic [ADDR_W-1:0]  addr_out;
        logic [ADDR_W-1:0]  addr_from;
        logic [ADDR_W-1:0]  addr_to;
        logic [ID_W-1:0]    tunnel_id;
        logic [ADDR_W-1:0]  pkt_src;
        logic [ADDR_W-1:0]  pkt_dst;
        logic [ADDR_W-1:0]  node_addr;
        logic [CLASS_W-1:0] pkt_class;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]    result_id;
        logic [POINT_W-1:0] point;
        logic               ignored;
        logic               table_full;
        logic [SLOT_W-1:0]  slot_index;
    } out_item_t;

    // One decoded command as it waits in the queue between front and back.
    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr_in;
        logic [ADDR_W-1:0] addr_out;
        logic [ADDR_W-1:0] addr_from;
        logic [ADDR_W-1:0] addr_to;
        logic [ID_W-1:0]   tunnel_id;
        logic [ADDR_W-1:0] pkt_src;
        logic [ADDR_W-1:0] pkt_dst;
        logic [ADDR_W-1:0] node_addr;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_in;
        logic [ADDR_W-1:0] addr_out;
        logic [ADDR_W-1:0] addr_from;
        logic [ADDR_W-1:0] addr_to;
        logic [ID_W-1:0]   id;
    } slot_entry_t;

    // Role of a node for a packet against one tunnel entry. Only the first
    // node comparison that holds decides.
    function automatic logic [POINT_W-1:0] role_of(
        slot_entry_t       e,
        logic [ADDR_W-1:0] node,
        logic [ADDR_W-1:0] src,
        logic [ADDR_W-1:0] dst
    );
        logic [POINT_W-1:0] r;
        r = POINT_NONE;
        if (node == e.addr_in) begin
            r = (dst == e.addr_from || src == e.addr_to) ? POINT_IN : POINT_NONE;
        end else if (node == e.addr_out) begin
            r = (src == e.addr_to || dst == e.addr_to) ? POINT_OUT : POINT_NONE;
        end else if (node == e.addr_from) begin
            r = (dst == e.addr_from || src == e.addr_from) ? POINT_FROM : POINT_NONE;
        end else if (node == e.addr_to) begin
            r = (dst == e.addr_to) ? POINT_TO : POINT_NONE;
        end
        return r;
    endfunction

endpackage

/* sv/tunnel_point_match_table.sv */
// Top level of the tunnel point match table.
//
// Commands arrive on the s_ channel (valid/ready) as one in_item_t: activate
// a tunnel, deactivate a tunnel by id, or classify a packet at a node. Each
// accepted transaction gives exactly one out_item_t transaction on the m_
// channel, in order. cfg_we/cfg_wdata write the ignored traffic class.
// The front end decodes commands into a two-entry queue, so it keeps taking
// transactions while the back end scans. The back end walks the table one
// slot per cycle: activate checks the valid flags, deactivate and classify
// read the slot RAM, whose read data is registered. An ignored packet or an
// unused kind skips the scan. The back end takes a new command only after
// the result of the last one reaches the output register, so the table
// scan sets the throughput. Results wait in an output register while
// m_ready is low; the back end then holds and the queue fills, after which
// s_ready drops. Reset empties the table, clears the id counter to zero and
// sets the ignored class to 2; slot contents need no clearing.
`timescale 1ns / 1ps

module tunnel_point_match_table import tpm_pkg::*; #(
    parameter int TABLE_DEPTH = TPM_TABLE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CLASS_W-1:0] cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data
);

    cmd_req_t cmd_req;
    logic     cmd_pop;

    tpm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_req   (cmd_req),
        .cmd_pop   (cmd_pop)
    );

    tpm_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd_req (cmd_req),
        .cmd_pop (cmd_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // The back end only takes a command that the queue actually holds.
    a_pop_needs_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> cmd_req.valid)
        else $error("command popped from an empty queue");

    // A queued command stays until the back end takes it.
    a_cmd_held: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_req.valid && !cmd_pop |=> cmd_req.valid)
        else $error("queued command lost before it was taken");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.ignored && m_data.table_full))
        else $error("result is both ignored and table full");

    // A full table reports nothing else.
    a_full_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.table_full |->
            (m_data.result_id == '0 && m_data.point == POINT_NONE
             && m_data.slot_index == '0))
        else $error("table full result carries other fields");

endmodule

/* sv/tpm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/tpm_front.sv */
// Front end: input channel, class register, command decode and command queue.
`timescale 1ns / 1ps

module tpm_front import tpm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CLASS_W-1:0] cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    output cmd_req_t           cmd_req,
    input  logic               cmd_pop
);

    localparam int QD    = CMD_QUEUE_DEPTH;
    localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
    localparam int CNT_W = $clog2(QD + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QD - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QD);

    logic [CLASS_W-1:0] ignore_class_reg;
    cmd_t               q_reg [QD];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    cmd_t               cmd_in;
    logic               push;

    always_comb begin
        cmd_in.addr_in   = s_data.addr_in;
        cmd_in.addr_out  = s_data.addr_out;
        cmd_in.addr_from = s_data.addr_from;
        cmd_in.addr_to   = s_data.addr_to;
        cmd_in.tunnel_id = s_data.tunnel_id;
        cmd_in.pkt_src   = s_data.pkt_src;
        cmd_in.pkt_dst   = s_data.pkt_dst;
        cmd_in.node_addr = s_data.node_addr;
        case (s_data.kind)
            KIND_ACTIVATE:   cmd_in.op = OP_ACTIVATE;
            KIND_DEACTIVATE: cmd_in.op = OP_DEACTIVATE;
            KIND_CLASSIFY: begin
                // Background traffic never reaches the table scan.
                cmd_in.op = (s_data.pkt_class == ignore_class_reg) ? OP_BYPASS
                                                                   : OP_CLASSIFY;
            end
            default:         cmd_in.op = OP_NOP;
        endcase
    end

    assign s_ready = (count_reg != CNT_FULL);
    assign push    = s_valid && s_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, cmd_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    assign cmd_req.valid = (count_reg != '0);
    assign cmd_req.cmd   = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ignore_class_reg <= IGNORE_CLASS_RESET;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
        end else begin
            if (cfg_we) begin
                ignore_class_reg <= cfg_wdata;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

/* sv/tpm_back.sv */
// Back end: slot-by-slot table scan, slot storage and result register.
`timescale 1ns / 1ps

module tpm_back import tpm_pkg::*; #(
    parameter int TABLE_DEPTH = TPM_TABLE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cmd_req_t  cmd_req,
    output logic      cmd_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = $bits(slot_entry_t);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FREE = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [ID_W-1:0]        next_id_reg, next_id_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]       issue_cnt_reg, issue_cnt_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    out_item_t              res_reg, res_next;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_data_reg, m_data_next;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_raddr;
    slot_entry_t            ram_wdata;
    logic [ENTRY_W-1:0]     ram_rdata;
    slot_entry_t            entry;
    logic [POINT_W-1:0]     role;
    logic                   scan_stop;
    logic [31:0]            free_ext, rd_ext;

    tpm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (IDX_W)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (free_idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign entry    = slot_entry_t'(ram_rdata);
    assign role     = role_of(entry, cmd_reg.node_addr, cmd_reg.pkt_src, cmd_reg.pkt_dst);
    assign free_ext = 32'(free_idx_reg);
    assign rd_ext   = 32'(rd_idx_reg);

    always_comb begin
        ram_wdata.addr_in   = cmd_reg.addr_in;
        ram_wdata.addr_out  = cmd_reg.addr_out;
        ram_wdata.addr_from = cmd_reg.addr_from;
        ram_wdata.addr_to   = cmd_reg.addr_to;
        ram_wdata.id        = next_id_reg;
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        valid_next     = valid_reg;
        next_id_next   = next_id_reg;
        free_idx_next  = free_idx_reg;
        issue_cnt_next = issue_cnt_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        res_next       = res_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;
        ram_raddr      = issue_cnt_reg[IDX_W-1:0];
        scan_stop      = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (cmd_req.valid) begin
                    cmd_pop        = 1'b1;
                    cmd_next       = cmd_req.cmd;
                    res_next       = '0;
                    free_idx_next  = '0;
                    issue_cnt_next = '0;
                    case (cmd_req.cmd.op)
                        OP_ACTIVATE:   state_next = S_FREE;
                        OP_DEACTIVATE: state_next = S_SCAN;
                        OP_CLASSIFY:   state_next = S_SCAN;
                        OP_BYPASS: begin
                            res_next.ignored = 1'b1;
                            state_next       = S_DONE;
                        end
                        default:       state_next = S_DONE;
                    endcase
                end
            end

            // Valid bits sit in flip-flops, so the free search needs no RAM read.
            S_FREE: begin
                if (!valid_reg[free_idx_reg]) begin
                    ram_we                   = 1'b1;
                    valid_next[free_idx_reg] = 1'b1;
                    res_next.result_id       = next_id_reg;
                    res_next.slot_index      = free_ext[SLOT_W-1:0];
                    next_id_next             = next_id_reg + 1'b1;
                    state_next               = S_DONE;
                end else if (free_idx_reg == LAST_IDX) begin
                    res_next.table_full = 1'b1;
                    state_next          = S_DONE;
                end else begin
                    free_idx_next = free_idx_reg + 1'b1;
                end
            end

            // Reads are issued one slot ahead; each returned entry is checked
            // the cycle after its address went out.
            S_SCAN: begin
                if (issue_cnt_reg != CNT_END) begin
                    rd_vld_next    = 1'b1;
                    rd_idx_next    = issue_cnt_reg[IDX_W-1:0];
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    if (cmd_reg.op == OP_DEACTIVATE) begin
                        if (valid_reg[rd_idx_reg] && entry.id == cmd_reg.tunnel_id) begin
                            valid_next[rd_idx_reg] = 1'b0;
                            scan_stop              = 1'b1;
                        end
                    end else if (valid_reg[rd_idx_reg] && role != POINT_NONE) begin
                        res_next.result_id  = entry.id;
                        res_next.point      = role;
                        res_next.slot_index = rd_ext[SLOT_W-1:0];
                        scan_stop           = 1'b1;
                    end
                    if (rd_idx_reg == LAST_IDX) begin
                        scan_stop = 1'b1;
                    end
                end
                if (scan_stop) begin
                    rd_vld_next = 1'b0;
                    state_next  = S_DONE;
                end
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            next_id_reg <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            next_id_reg <= next_id_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        free_idx_reg  <= free_idx_next;
        issue_cnt_reg <= issue_cnt_next;
        rd_idx_reg    <= rd_idx_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
